FILE: rtl/core/dual_pid_drive_controller_defines.svh
// assertion macros used by the dual pid drive controller checker
`ifndef DUAL_PID_DRIVE_CONTROLLER_DEFINES_SVH
`define DUAL_PID_DRIVE_CONTROLLER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define DPDC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dpdc check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define DPDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dpdc check failed");

`endif

FILE: rtl/core/dpdc_pkg.sv
// shared types, widths and register map of the dual pid drive controller
package dpdc_pkg;

  localparam int FRAC      = 12;
  localparam int FRAC_MASK = (1 << FRAC) - 1;

  localparam int GAIN_W   = 16;
  localparam int POS_W    = 24;
  localparam int HEAD_W   = 16;
  localparam int HRAW_W   = 9;
  localparam int ERR_W    = 25;
  localparam int RERR_W   = 17;
  localparam int HWRAP_W  = 10;
  localparam int P_W      = 40;
  localparam int DIFF_W   = 41;
  localparam int D_W      = 45;
  localparam int ACC_W    = 48;
  localparam int MUL_B_W  = 48;
  localparam int PROD_W   = 64;
  localparam int PWR_W    = 52;
  localparam int VEL_W    = 16;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;

  // input tdata layout, lowest bit first
  localparam int TDIST_LSB   = 0;
  localparam int THEAD_LSB   = TDIST_LSB + POS_W;
  localparam int LPOS_LSB    = THEAD_LSB + HEAD_W;
  localparam int RPOS_LSB    = LPOS_LSB + POS_W;
  localparam int HRAW_LSB    = RPOS_LSB + POS_W;
  localparam int S_TDATA_W   = ((HRAW_LSB + HRAW_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = 2 * VEL_W;

  localparam logic [HRAW_W-1:0]          HEAD_HALF_TURN = 9'd180;
  localparam logic signed [HWRAP_W-1:0]  HEAD_FULL_TURN = 10'sd360;

  localparam logic signed [P_W-1:0] LAT_INT_LIM  = 40'sd880640;  // 215 in q.12
  localparam logic signed [P_W-1:0] ROT_INT_LIM  = 40'sd20480;   // 5 in q.12
  localparam logic signed [P_W-1:0] LAT_DONE_TOL = 40'sd264773;  // about 64.64 in q.12
  localparam logic signed [P_W-1:0] ROT_DONE_TOL = 40'sd6144;    // 1.5 in q.12

  localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAT_KP   = 3'd0,
    REG_LAT_KD   = 3'd1,
    REG_LAT_KI   = 3'd2,
    REG_LAT_GAIN = 3'd3,
    REG_ROT_KP   = 3'd4,
    REG_ROT_KD   = 3'd5,
    REG_ROT_KI   = 3'd6,
    REG_ROT_GAIN = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] kd;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] out_gain;
  } pid_gains_t;

  // one command bit per sequencer step
  typedef struct packed {
    logic load_in;
    logic calc_err;
    logic mul_p;
    logic mul_d;
    logic mul_i;
    logic upd_int;
    logic upd_sum;
    logic mul_g;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic enable;
    logic out_free;
  } dp_status_t;

  function automatic logic [GAIN_W-1:0] reg_reset(input cfg_reg_e idx);
    logic [GAIN_W-1:0] v;
    unique case (idx)
      REG_LAT_KP:   v = 16'd3686;
      REG_LAT_KD:   v = 16'd5734;
      REG_LAT_KI:   v = 16'd0;
      REG_LAT_GAIN: v = 16'd4096;
      REG_ROT_KP:   v = 16'd4915;
      REG_ROT_KD:   v = 16'd2048;
      REG_ROT_KI:   v = 16'd0;
      REG_ROT_GAIN: v = 16'd11059;
      default:      v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/dual_pid_drive_controller.sv
// top level of the dual pid drive controller: sequencer plus datapath
// enabled tick: error calc, then p, d, i, integral update, sum and gain, then output once the output register is free
// disabled tick: error calc, then output; the next input is taken once the sequencer is back in idle
// rate is set by the step sequence of each lane's single 16x48 multiplier (p, d, i, gain)
// a finished result waits in the output register while the next transaction is taken
// reset clears gains to defaults and both pid loops' state, no clearing pass
module dual_pid_drive_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [23:0] target_distance, [39:24] target_heading, [63:40] left_position,
  // [87:64] right_position, [96:88] heading_raw, [103:97] zero
  input  logic [dpdc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [0] enable
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] left_velocity, [31:16] right_velocity
  output logic [dpdc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] done_res
  output logic                                m_axis_tuser,
  // gain register writes, index follows the register map in the package
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dpdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dpdc_pkg::GAIN_W-1:0]         cfg_data_i
);

  // command bits from the sequencer, one per step
  dpdc_pkg::dp_cmd_t    cmd;
  // enable flag of the held transaction and output register space
  dpdc_pkg::dp_status_t status;

  // sequencer: idle, error calc, then p, d, i, integral update, sum, gain, output;
  // a disabled tick goes from error calc straight to output and leaves loop state alone
  dpdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: lateral lane works on distance, rotational lane on heading;
  // left is lateral plus rotational, right is lateral minus rotational
  dpdc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

FILE: rtl/core/dpdc_ctrl.sv
// sequencer state machine of the dual pid drive controller
module dpdc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  dpdc_pkg::dp_status_t status_i,
  output dpdc_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_ERR   = 9'b000000010,
    ST_MUL_P = 9'b000000100,
    ST_MUL_D = 9'b000001000,
    ST_MUL_I = 9'b000010000,
    ST_INTEG = 9'b000100000,
    ST_SUM   = 9'b001000000,
    ST_GAIN  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_tvalid_i) state_d = ST_ERR;
      ST_ERR:   state_d = status_i.enable ? ST_MUL_P : ST_OUT;
      ST_MUL_P: state_d = ST_MUL_D;
      ST_MUL_D: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_INTEG;
      ST_INTEG: state_d = ST_SUM;
      ST_SUM:   state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_OUT;
      ST_OUT:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o     = (state_q == ST_IDLE);
  assign cmd_o.load_in  = (state_q == ST_IDLE) && s_tvalid_i;
  assign cmd_o.calc_err = (state_q == ST_ERR);
  assign cmd_o.mul_p    = (state_q == ST_MUL_P);
  assign cmd_o.mul_d    = (state_q == ST_MUL_D);
  assign cmd_o.mul_i    = (state_q == ST_MUL_I);
  assign cmd_o.upd_int  = (state_q == ST_INTEG);
  assign cmd_o.upd_sum  = (state_q == ST_SUM);
  assign cmd_o.mul_g    = (state_q == ST_GAIN);
  assign cmd_o.load_out = (state_q == ST_OUT) && status_i.out_free;

endmodule

FILE: rtl/core/dpdc_pid.sv
// one pid channel: shared multiplier, term registers and loop state
module dpdc_pid (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dpdc_pkg::dp_cmd_t                      cmd_i,
  input  dpdc_pkg::pid_gains_t                   gains_i,
  input  logic signed [dpdc_pkg::ERR_W-1:0]      err_i,
  input  logic signed [dpdc_pkg::P_W-1:0]        int_lim_i,
  output logic signed [dpdc_pkg::PWR_W-1:0]      pwr_o,
  output logic signed [dpdc_pkg::P_W-1:0]        prev_o
);

  function automatic logic signed [dpdc_pkg::ACC_W-1:0] sat_acc(
    input logic signed [dpdc_pkg::ACC_W+1:0] x
  );
    logic signed [dpdc_pkg::ACC_W-1:0] r;
    if ((x[dpdc_pkg::ACC_W+1:dpdc_pkg::ACC_W-1] == 3'b000) ||
        (x[dpdc_pkg::ACC_W+1:dpdc_pkg::ACC_W-1] == 3'b111)) begin
      r = x[dpdc_pkg::ACC_W-1:0];
    end else if (x[dpdc_pkg::ACC_W+1]) begin
      r = {1'b1, {(dpdc_pkg::ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(dpdc_pkg::ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic signed [dpdc_pkg::PROD_W-1:0]  prod_q;
  logic signed [dpdc_pkg::P_W-1:0]     p_q;
  logic signed [dpdc_pkg::D_W-1:0]     d_q;
  logic signed [dpdc_pkg::ACC_W-1:0]   sum_q;
  logic signed [dpdc_pkg::ACC_W-1:0]   integ_q, integ_d;
  logic signed [dpdc_pkg::P_W-1:0]     prev_q;

  logic signed [dpdc_pkg::PROD_W-1:0]  prod_sh;
  logic signed [dpdc_pkg::PROD_W-1:0]  prod;
  logic signed [dpdc_pkg::GAIN_W-1:0]  mul_a;
  logic signed [dpdc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [dpdc_pkg::MUL_B_W-1:0] err_w, diff_w, p_b;
  logic signed [dpdc_pkg::DIFF_W-1:0]  pnew_w, prev_w, diff;
  logic signed [dpdc_pkg::ACC_W+1:0]   p_w, d_w, i_w, step_w, integ_sum, sum_all;
  logic                                in_zone;

  assign prod_sh = prod_q >>> dpdc_pkg::FRAC;

  // change of scaled error against the previous tick
  assign pnew_w = $signed(prod_q[dpdc_pkg::P_W-1:0]);
  assign prev_w = prev_q;
  assign diff   = pnew_w - prev_w;

  assign err_w  = err_i;
  assign diff_w = diff;
  assign p_b    = p_q;

  always_comb begin
    mul_a = gains_i.out_gain;
    mul_b = sum_q;
    if (cmd_i.mul_p) begin
      mul_a = gains_i.kp;
      mul_b = err_w;
    end else if (cmd_i.mul_d) begin
      mul_a = gains_i.kd;
      mul_b = diff_w;
    end else if (cmd_i.mul_i) begin
      mul_a = gains_i.ki;
      mul_b = p_b;
    end
  end

  assign prod = mul_a * mul_b;

  // integral runs only outside the bound, cleared inside it
  assign p_w       = p_q;
  assign d_w       = d_q;
  assign i_w       = integ_q;
  assign step_w    = $signed(prod_sh[dpdc_pkg::ACC_W+1:0]);
  assign integ_sum = i_w + step_w;
  assign in_zone   = (p_q > int_lim_i) || (p_q < -int_lim_i);
  assign integ_d   = in_zone ? sat_acc(integ_sum) : '0;
  assign sum_all   = p_w + d_w + i_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_p || cmd_i.mul_d || cmd_i.mul_i || cmd_i.mul_g) begin
      prod_q <= prod;
    end
    if (cmd_i.mul_d) begin
      p_q <= prod_q[dpdc_pkg::P_W-1:0];
    end
    if (cmd_i.mul_i) begin
      d_q <= prod_sh[dpdc_pkg::D_W-1:0];
    end
    if (cmd_i.upd_sum) begin
      sum_q <= sat_acc(sum_all);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (cmd_i.upd_int) begin
      integ_q <= integ_d;
      prev_q  <= p_q;
    end
  end

  assign pwr_o  = prod_sh[dpdc_pkg::PWR_W-1:0];
  assign prev_o = prev_q;

endmodule

FILE: rtl/core/dpdc_datapath.sv
// datapath: gain registers, input capture, errors, two pid lanes, output register
module dpdc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dpdc_pkg::dp_cmd_t                   cmd_i,
  output dpdc_pkg::dp_status_t                status_o,
  input  logic [dpdc_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  logic                                s_tuser_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [dpdc_pkg::M_TDATA_W-1:0]      m_tdata_o,
  output logic                                m_tuser_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dpdc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dpdc_pkg::GAIN_W-1:0]         cfg_data_i
);

  function automatic logic signed [dpdc_pkg::VEL_W-1:0] to_vel(
    input logic signed [dpdc_pkg::PWR_W:0] x
  );
    logic signed [dpdc_pkg::PWR_W+1:0] adj;
    logic signed [dpdc_pkg::PWR_W+1:0] q;
    logic signed [dpdc_pkg::VEL_W-1:0] r;
    adj = x;
    if (x[dpdc_pkg::PWR_W]) begin
      adj = adj + dpdc_pkg::FRAC_MASK;
    end
    q = adj >>> dpdc_pkg::FRAC;
    if (q > dpdc_pkg::VEL_MAX) begin
      r = dpdc_pkg::VEL_MAX;
    end else if (q < dpdc_pkg::VEL_MIN) begin
      r = dpdc_pkg::VEL_MIN;
    end else begin
      r = q[dpdc_pkg::VEL_W-1:0];
    end
    return r;
  endfunction

  logic [dpdc_pkg::GAIN_W-1:0] cfg_q [dpdc_pkg::NUM_REGS];

  logic                                en_q;
  logic signed [dpdc_pkg::POS_W-1:0]   tdist_q, lpos_q, rpos_q;
  logic signed [dpdc_pkg::HEAD_W-1:0]  thead_q;
  logic [dpdc_pkg::HRAW_W-1:0]         hraw_q;
  logic signed [dpdc_pkg::ERR_W-1:0]   lat_err_q, lat_err_d;
  logic signed [dpdc_pkg::RERR_W-1:0]  rot_err_q, rot_err_d;

  logic                                m_valid_q;
  logic [dpdc_pkg::M_TDATA_W-1:0]      m_data_q, m_data_d;
  logic                                m_user_q, m_user_d;

  dpdc_pkg::pid_gains_t                lat_gains, rot_gains;
  logic signed [dpdc_pkg::ERR_W-1:0]   rot_err_w;
  logic signed [dpdc_pkg::PWR_W-1:0]   lat_pwr, rot_pwr;
  logic signed [dpdc_pkg::P_W-1:0]     lat_prev, rot_prev;

  logic signed [dpdc_pkg::ERR_W-1:0]   lpos_w, rpos_w, tdist_w, pos_sum, pos_adj, avg;
  logic signed [dpdc_pkg::HWRAP_W-1:0] hraw_w, head;
  logic signed [dpdc_pkg::RERR_W-1:0]  thead_w, head_w;
  logic signed [dpdc_pkg::PWR_W:0]     left_sum, right_sum;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dpdc_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= dpdc_pkg::reg_reset(dpdc_pkg::cfg_reg_e'(i));
      end
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  assign lat_gains.kp       = cfg_q[dpdc_pkg::REG_LAT_KP];
  assign lat_gains.kd       = cfg_q[dpdc_pkg::REG_LAT_KD];
  assign lat_gains.ki       = cfg_q[dpdc_pkg::REG_LAT_KI];
  assign lat_gains.out_gain = cfg_q[dpdc_pkg::REG_LAT_GAIN];
  assign rot_gains.kp       = cfg_q[dpdc_pkg::REG_ROT_KP];
  assign rot_gains.kd       = cfg_q[dpdc_pkg::REG_ROT_KD];
  assign rot_gains.ki       = cfg_q[dpdc_pkg::REG_ROT_KI];
  assign rot_gains.out_gain = cfg_q[dpdc_pkg::REG_ROT_GAIN];

  // input capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      en_q <= s_tuser_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tdist_q <= s_tdata_i[dpdc_pkg::TDIST_LSB +: dpdc_pkg::POS_W];
      thead_q <= s_tdata_i[dpdc_pkg::THEAD_LSB +: dpdc_pkg::HEAD_W];
      lpos_q  <= s_tdata_i[dpdc_pkg::LPOS_LSB  +: dpdc_pkg::POS_W];
      rpos_q  <= s_tdata_i[dpdc_pkg::RPOS_LSB  +: dpdc_pkg::POS_W];
      hraw_q  <= s_tdata_i[dpdc_pkg::HRAW_LSB  +: dpdc_pkg::HRAW_W];
    end
    if (cmd_i.calc_err) begin
      lat_err_q <= lat_err_d;
      rot_err_q <= rot_err_d;
    end
  end

  // encoder average truncated toward zero
  assign lpos_w    = lpos_q;
  assign rpos_w    = rpos_q;
  assign tdist_w   = tdist_q;
  assign pos_sum   = lpos_w + rpos_w;
  assign pos_adj   = pos_sum + $signed({{(dpdc_pkg::ERR_W-1){1'b0}}, pos_sum[dpdc_pkg::ERR_W-1]});
  assign avg       = pos_adj >>> 1;
  assign lat_err_d = tdist_w - avg;

  // heading past half a turn wraps negative
  assign hraw_w    = $signed({1'b0, hraw_q});
  assign head      = (hraw_q > dpdc_pkg::HEAD_HALF_TURN) ? hraw_w - dpdc_pkg::HEAD_FULL_TURN
                                                         : hraw_w;
  assign thead_w   = thead_q;
  assign head_w    = head;
  assign rot_err_d = thead_w - head_w;
  assign rot_err_w = rot_err_q;

  dpdc_pid u_lat_pid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .gains_i   (lat_gains),
    .err_i     (lat_err_q),
    .int_lim_i (dpdc_pkg::LAT_INT_LIM),
    .pwr_o     (lat_pwr),
    .prev_o    (lat_prev)
  );

  dpdc_pid u_rot_pid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .gains_i   (rot_gains),
    .err_i     (rot_err_w),
    .int_lim_i (dpdc_pkg::ROT_INT_LIM),
    .pwr_o     (rot_pwr),
    .prev_o    (rot_prev)
  );

  // mix to left and right, zero while disabled
  assign left_sum  = lat_pwr + rot_pwr;
  assign right_sum = lat_pwr - rot_pwr;

  always_comb begin
    if (en_q) begin
      m_data_d = {to_vel(right_sum), to_vel(left_sum)};
    end else begin
      m_data_d = '0;
    end
    m_user_d = (lat_prev <= dpdc_pkg::LAT_DONE_TOL) && (lat_prev >= -dpdc_pkg::LAT_DONE_TOL) &&
               (rot_prev <= dpdc_pkg::ROT_DONE_TOL) && (rot_prev >= -dpdc_pkg::ROT_DONE_TOL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
    end
  end

  assign m_tvalid_o      = m_valid_q;
  assign m_tdata_o       = m_data_q;
  assign m_tuser_o       = m_user_q;
  assign status_o.enable   = en_q;
  assign status_o.out_free = !m_valid_q || m_tready_i;

endmodule

FILE: rtl/core/dpdc_checker.sv
// port-level checker for the dual pid drive controller, bound to the top level
`include "dual_pid_drive_controller_defines.svh"

module dpdc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [dpdc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input logic                              m_axis_tuser
);

  // a stalled result keeps its valid and payload
  `DPDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // one transaction in flight: input closes right after a transaction
  `DPDC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // no result can show up in the cycle right after a transaction
  `DPDC_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

  // a new result only comes out of a busy block
  `DPDC_ASSERT_SAME(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind dual_pid_drive_controller dpdc_checker u_dpdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_top.sv
// testbench of the dual pid drive controller: directed and random ticks checked by a local model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpdc_pkg::*;

  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     SETTLE_CYCLES  = 12;
  localparam longint ACC_MAX        = (longint'(1) <<< 47) - 1;
  localparam longint ACC_MIN        = -(longint'(1) <<< 47);
  localparam longint LAT_BOUND_Q12  = 215 * 4096;
  localparam longint ROT_BOUND_Q12  = 5 * 4096;
  localparam longint LAT_TOL_Q12    = 264773;
  localparam longint ROT_TOL_Q12    = 6144;

  typedef struct packed {
    logic                     enable;
    logic signed [POS_W-1:0]  tdist;
    logic signed [HEAD_W-1:0] thead;
    logic signed [POS_W-1:0]  lpos;
    logic signed [POS_W-1:0]  rpos;
    logic [HRAW_W-1:0]        hraw;
  } tick_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] left;
    logic signed [VEL_W-1:0] right;
    logic                    done;
  } drive_t;

  typedef logic [GAIN_W-1:0] gain_set_t [NUM_REGS];

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [GAIN_W-1:0]      cfg_data_i;

  dual_pid_drive_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // controller image: gains and the two loops' state
  logic signed [GAIN_W-1:0] gain_copy [NUM_REGS];
  longint lat_prev_p, lat_acc, rot_prev_p, rot_acc;

  drive_t pending_drive [$];

  bit steady_run = 1'b0;
  bit hold_req   = 1'b0;
  int mismatches     = 0;
  int ticks_sent     = 0;
  int enabled_ticks  = 0;
  int done_ticks     = 0;
  int saturated_vels = 0;
  int gain_writes    = 0;
  int results_seen   = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic longint clamp48(input longint x);
    return (x > ACC_MAX) ? ACC_MAX : ((x < ACC_MIN) ? ACC_MIN : x);
  endfunction

  // one loop: returns q.12 power, updates the loop's previous p and integral
  function automatic longint pid_channel(input longint err, input longint kp,
                                         input longint kd, input longint ki,
                                         input longint out_gain, input longint bound,
                                         inout longint prev_p, inout longint acc);
    longint p, d;
    p = kp * err;
    d = (kd * (p - prev_p)) >>> FRAC;
    // integral runs only outside the bound, cleared inside it
    if (((p < 0) ? -p : p) > bound) acc = clamp48(acc + ((ki * p) >>> FRAC));
    else acc = 0;
    prev_p = p;
    return (clamp48(p + d + acc) * out_gain) >>> FRAC;
  endfunction

  function automatic logic signed [VEL_W-1:0] to_drive(input longint q12);
    longint v;
    v = q12 / 4096;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return VEL_W'(v);
  endfunction

  function automatic drive_t predict_drive(input tick_t t);
    drive_t r;
    longint head, avg, lat_pwr, rot_pwr;
    r = '0;
    if (t.enable) begin
      head = (t.hraw > 180) ? longint'(t.hraw) - 360 : longint'(t.hraw);
      avg  = (longint'(t.lpos) + longint'(t.rpos)) / 2;
      lat_pwr = pid_channel(longint'(t.tdist) - avg, gain_copy[REG_LAT_KP],
                            gain_copy[REG_LAT_KD], gain_copy[REG_LAT_KI],
                            gain_copy[REG_LAT_GAIN], LAT_BOUND_Q12, lat_prev_p, lat_acc);
      rot_pwr = pid_channel(longint'(t.thead) - head, gain_copy[REG_ROT_KP],
                            gain_copy[REG_ROT_KD], gain_copy[REG_ROT_KI],
                            gain_copy[REG_ROT_GAIN], ROT_BOUND_Q12, rot_prev_p, rot_acc);
      r.left  = to_drive(lat_pwr + rot_pwr);
      r.right = to_drive(lat_pwr - rot_pwr);
    end
    // a disabled tick sees the stored errors
    r.done = (((lat_prev_p < 0) ? -lat_prev_p : lat_prev_p) <= LAT_TOL_Q12) &&
             (((rot_prev_p < 0) ? -rot_prev_p : rot_prev_p) <= ROT_TOL_Q12);
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic tick_t mk_tick(input bit en, input int tdist, input int thead,
                                    input int lpos, input int rpos, input int hraw);
    tick_t t;
    t.enable = en;
    t.tdist  = POS_W'(tdist);
    t.thead  = HEAD_W'(thead);
    t.lpos   = POS_W'(lpos);
    t.rpos   = POS_W'(rpos);
    t.hraw   = HRAW_W'(hraw);
    return t;
  endfunction

  // near-target tracking, mid-size errors and fully random words, the random share set by wide_pct
  function automatic tick_t random_tick(input int wide_pct);
    tick_t t;
    int    sel, base, head, hraw;
    sel  = $urandom_range(0, 99);
    hraw = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 359) : $urandom_range(360, 511);
    head = (hraw > 180) ? hraw - 360 : hraw;
    base = int'($urandom_range(0, 16000000)) - 8000000;
    if (sel < wide_pct) begin
      t.tdist = POS_W'($urandom);
      t.thead = HEAD_W'($urandom);
      t.lpos  = POS_W'($urandom);
      t.rpos  = POS_W'($urandom);
    end else if (sel < wide_pct + (100 - wide_pct) / 3) begin
      t.tdist = POS_W'(base + int'($urandom_range(0, 200000)) - 100000);
      t.lpos  = POS_W'(base + int'($urandom_range(0, 200000)) - 100000);
      t.rpos  = POS_W'(base + int'($urandom_range(0, 200000)) - 100000);
      t.thead = HEAD_W'(head + int'($urandom_range(0, 800)) - 400);
    end else begin
      t.tdist = POS_W'(base + int'($urandom_range(0, 300)) - 150);
      t.lpos  = POS_W'(base + int'($urandom_range(0, 400)) - 200);
      t.rpos  = POS_W'(base + int'($urandom_range(0, 400)) - 200);
      t.thead = HEAD_W'(head + int'($urandom_range(0, 8)) - 4);
    end
    t.hraw   = HRAW_W'(hraw);
    t.enable = ($urandom_range(0, 99) < 88);
    return t;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4, 5: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 8192));
    endcase
  endfunction

  // offer one tick, wait for its transaction, then log what it must produce
  task automatic send_tick(input tick_t t);
    logic [S_TDATA_W-1:0] word;
    drive_t               want;
    word = '0;
    word[TDIST_LSB +: POS_W]  = t.tdist;
    word[THEAD_LSB +: HEAD_W] = t.thead;
    word[LPOS_LSB +: POS_W]   = t.lpos;
    word[RPOS_LSB +: POS_W]   = t.rpos;
    word[HRAW_LSB +: HRAW_W]  = t.hraw;
    @(negedge clk_i);
    if (!steady_run && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      // idle only once the block could take the tick, so the gap is seen
      while (!s_axis_tready) @(negedge clk_i);
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= t.enable;
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_drive(t);
    pending_drive.push_back(want);
    ticks_sent++;
    if (t.enable) enabled_ticks++;
    if (want.done) done_ticks++;
    if (want.left == VEL_MAX || want.left == VEL_MIN || want.right == VEL_MAX ||
        want.right == VEL_MIN) saturated_vels++;
  endtask

  task automatic send_random(input int count, input int wide_pct);
    repeat (count) send_tick(random_tick(wide_pct));
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input cfg_reg_e idx, input logic [GAIN_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    gain_copy[idx] = val;
    gain_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // gains change only with the pipeline empty
  task automatic load_gains(input gain_set_t g);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < NUM_REGS; i++) write_gain(cfg_reg_e'(i), g[i]);
  endtask

  // ------------------------------------------------------------- checking

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk_i) begin : check_results
    drive_t want;
    logic signed [VEL_W-1:0] got_left, got_right;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_left  = m_axis_tdata[VEL_W-1:0];
      got_right = m_axis_tdata[2*VEL_W-1:VEL_W];
      results_seen++;
      if (pending_drive.size() == 0) begin
        note_mismatch($sformatf("result %0d with no tick outstanding: left %0d right %0d",
                                results_seen, got_left, got_right));
      end else begin
        want = pending_drive.pop_front();
        if (got_left !== want.left || got_right !== want.right ||
            m_axis_tuser !== want.done)
          note_mismatch($sformatf(
            "result %0d: expected left %0d right %0d done %0b, got left %0d right %0d done %0b",
            results_seen, want.left, want.right, want.done, got_left, got_right,
            m_axis_tuser));
      end
    end
  end

  // receiver: random stalls, a long hold on request, none during the steady stretch
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (steady_run) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // ends the run when no transaction of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("[dual_pid_drive_controller] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // default gains: field extremes, heading wrap, odd encoder sums, disabled ticks
  task automatic test_default_gains();
    send_tick(mk_tick(1'b0, 12345, -77, 400, -9000, 359));
    send_tick(mk_tick(1'b1, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1'b1, 8388607, 32767, -8388608, -8388608, 0));
    send_tick(mk_tick(1'b1, -8388608, -32768, 8388607, 8388607, 359));
    send_tick(mk_tick(1'b1, 100, 180, 100, 100, 180));
    send_tick(mk_tick(1'b1, 100, -179, 100, 100, 181));
    send_tick(mk_tick(1'b1, 0, 0, 0, 0, 360));
    send_tick(mk_tick(1'b1, 0, 151, 0, 0, 511));
    send_tick(mk_tick(1'b1, -1, 0, -3, 0, 0));
    send_tick(mk_tick(1'b0, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1'b1, 5000, 90, 4960, 5020, 90));
    send_tick(mk_tick(1'b0, -8388608, 32767, 8388607, -1, 511));
  endtask

  // extreme gains drive the integrals and the drive commands into saturation
  task automatic test_gain_extremes();
    gain_set_t g;
    g = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    load_gains(g);
    repeat (6) send_tick(mk_tick(1'b1, 8388607, -32768, -8388608, -8388608, 180));
    send_tick(mk_tick(1'b1, 0, 0, 0, 0, 0));
    send_tick(mk_tick(1'b0, 1, 1, 1, 1, 1));
    send_tick(mk_tick(1'b1, -8388608, 32767, 8388607, 8388607, 181));
    send_random(150, 50);
    g = '{default: 16'h7FFF};
    load_gains(g);
    send_random(60, 40);
    g = '{default: 16'h8000};
    load_gains(g);
    send_random(60, 40);
  endtask

  // several random gain settings, out gains of zero among them
  task automatic test_random_gains();
    gain_set_t g;
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < NUM_REGS; i++) g[i] = random_gain();
      if (phase == 2) begin
        g[REG_LAT_GAIN] = '0;
        g[REG_ROT_GAIN] = '0;
      end
      load_gains(g);
      send_random(200, 10);
    end
  endtask

  // receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_random(40, 10);
  endtask

  task automatic test_steady_stream();
    steady_run = 1'b1;
    send_random(150, 10);
    steady_run = 1'b0;
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_sender_pause();
    send_random(25, 10);
    wait_for_results();
    send_random(25, 10);
  endtask

  initial begin : main
    // power-on image of the gains
    gain_copy[REG_LAT_KP]   = 16'sd3686;
    gain_copy[REG_LAT_KD]   = 16'sd5734;
    gain_copy[REG_LAT_KI]   = 16'sd0;
    gain_copy[REG_LAT_GAIN] = 16'sd4096;
    gain_copy[REG_ROT_KP]   = 16'sd4915;
    gain_copy[REG_ROT_KD]   = 16'sd2048;
    gain_copy[REG_ROT_KI]   = 16'sd0;
    gain_copy[REG_ROT_GAIN] = 16'sd11059;
    lat_prev_p = 0;
    lat_acc    = 0;
    rot_prev_p = 0;
    rot_acc    = 0;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_LAT_KP;
    cfg_data_i    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_gains();
    test_gain_extremes();
    test_random_gains();
    test_backpressure();
    test_steady_stream();
    test_sender_pause();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d ticks (%0d enabled), %0d with done set, %0d with a saturated drive",
             ticks_sent, enabled_ticks, done_ticks, saturated_vels);
    $display("%0d gain writes, %0d results checked, %0d mismatches",
             gain_writes, results_seen, mismatches);
    if (mismatches == 0)
      $display("[dual_pid_drive_controller] OK");
    else
      $display("[dual_pid_drive_controller] ERROR");
    $finish;
  end

endmodule

FILE: dual_pid_drive_controller.f
+incdir+rtl/core
rtl/core/dpdc_pkg.sv
rtl/core/dpdc_ctrl.sv
rtl/core/dpdc_pid.sv
rtl/core/dpdc_datapath.sv
rtl/core/dual_pid_drive_controller.sv
rtl/core/dpdc_checker.sv
tb/sv/tb_top.sv
